/* rtl/bdeb_pkg.sv */
// Shared constants, command codes and item types of the boolean bit decoder.
package bdeb_pkg;

    localparam int STORE_DEPTH   = 4096;
    localparam int MAX_READ_BITS = 32;
    localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [7:0] RANGE_NORM   = 8'h80;
    localparam logic [3:0] REFILL_COUNT = 4'd8;
    localparam int         SPLIT_SHIFT  = 24;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] byte_address;
        logic [7:0]  byte_data;
        logic [31:0] start_value;
        logic [7:0]  start_range;
        logic [3:0]  start_count;
        logic [12:0] start_position;
        logic [5:0]  bit_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_bits;
        logic        stream_error;
    } t_out_item;

    // Coder state handed to the bit step
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  range;
        logic [3:0]  count;
        logic [12:0] position;
    } t_coder;

    // Outcome of one decoded bit
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  range;
        logic [3:0]  count;
        logic        bit_out;
        logic        refill;
        logic        fail;
    } t_step;

endpackage

/* rtl/bool_decoder_equiprobable_bits_top.sv */
// Top level of the equiprobable boolean bit decoder: control, coder registers, byte store.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_data: stream end, 13 bit
//  in      | in        | i_in_valid/o_in_ready  | i_in_data: bdeb_pkg::t_in_item
//  out     | out       | o_out_valid/i_out_ready| o_out_data: bdeb_pkg::t_out_item
//
// Write, start and unused items answer in the cycle after acceptance.
// A read of n bits runs in S_DECODE at one bit per cycle through the step unit,
// except that each byte refill passes through S_FETCH to wait on the byte
// store's registered read port; S_FETCH also shifts in that refill's bit.
// Synchronous active-low reset clears the coder state and control; the store is not cleared.
// A stalled result holds in the output register; one item is worked on at a time.
module bool_decoder_equiprobable_bits_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bdeb_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bdeb_pkg::t_out_item  o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_FETCH  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [12:0]         r_stream_end;
    bdeb_pkg::t_coder    r_coder, n_coder;
    logic                r_error, n_error;
    logic [5:0]          r_left, n_left;
    logic [31:0]         r_bits, n_bits;
    logic [31:0]         r_pend_value, n_pend_value;
    logic [7:0]          r_pend_range, n_pend_range;
    logic                r_pend_bit, n_pend_bit;
    logic                r_out_valid, n_out_valid;
    bdeb_pkg::t_out_item r_out_data, n_out_data;

    bdeb_pkg::t_step     step;
    logic                accept;
    logic                ram_we;
    logic [31:0]         waddr_ext;
    logic [31:0]         raddr_ext;
    logic [7:0]          ram_rdata;
    logic [7:0]          refill_byte;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign waddr_ext = {20'd0, i_in_data.byte_address};
    assign raddr_ext = {19'd0, r_coder.position};
    assign ram_we    = accept && (i_in_data.cmd == bdeb_pkg::CMD_WRITE)
                       && (waddr_ext < 32'(bdeb_pkg::STORE_DEPTH));
    // positions past the store refill zero
    assign refill_byte = (raddr_ext < 32'(bdeb_pkg::STORE_DEPTH)) ? ram_rdata : 8'd0;

    bdeb_ram #(
        .WIDTH (8),
        .DEPTH (bdeb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_ext[bdeb_pkg::ADDR_W-1:0]),
        .i_wdata (i_in_data.byte_data),
        .i_raddr (raddr_ext[bdeb_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    bdeb_step u_step (
        .i_coder      (r_coder),
        .i_stream_end (r_stream_end),
        .o_step       (step)
    );

    always_comb begin
        n_state      = r_state;
        n_coder      = r_coder;
        n_error      = r_error;
        n_left       = r_left;
        n_bits       = r_bits;
        n_pend_value = r_pend_value;
        n_pend_range = r_pend_range;
        n_pend_bit   = r_pend_bit;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.cmd)
                        bdeb_pkg::CMD_START: begin
                            n_coder.value    = i_in_data.start_value;
                            n_coder.range    = i_in_data.start_range;
                            n_coder.count    = i_in_data.start_count;
                            n_coder.position = i_in_data.start_position;
                            n_error          = 1'b0;
                            n_out_valid      = 1'b1;
                            n_out_data       = '{read_bits: 32'd0, stream_error: 1'b0};
                        end
                        bdeb_pkg::CMD_READ: begin
                            n_left  = (i_in_data.bit_count > 6'(bdeb_pkg::MAX_READ_BITS))
                                      ? 6'(bdeb_pkg::MAX_READ_BITS) : i_in_data.bit_count;
                            n_bits  = 32'd0;
                            n_state = S_DECODE;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = '{read_bits: 32'd0, stream_error: r_error};
                        end
                    endcase
                end
            end
            S_DECODE: begin
                if (r_left == 6'd0) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{read_bits: r_bits, stream_error: r_error};
                    n_state     = S_IDLE;
                end else if (step.refill) begin
                    // hold the shifted state until the byte arrives
                    n_pend_value = step.value;
                    n_pend_range = step.range;
                    n_pend_bit   = step.bit_out;
                    n_state      = S_FETCH;
                end else begin
                    n_bits = {r_bits[30:0], step.bit_out};
                    n_left = r_left - 6'd1;
                    if (step.fail) begin
                        n_error = 1'b1;
                    end else begin
                        n_coder.value = step.value;
                        n_coder.range = step.range;
                        n_coder.count = step.count;
                    end
                end
            end
            S_FETCH: begin
                n_coder.value    = r_pend_value | {24'd0, refill_byte};
                n_coder.range    = r_pend_range;
                n_coder.count    = bdeb_pkg::REFILL_COUNT;
                n_coder.position = r_coder.position + 13'd1;
                n_bits           = {r_bits[30:0], r_pend_bit};
                n_left           = r_left - 6'd1;
                n_state          = S_DECODE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stream_end <= 13'd0;
            r_coder      <= '0;
            r_error      <= 1'b0;
            r_left       <= 6'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_coder     <= n_coder;
            r_error     <= n_error;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_stream_end <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits       <= n_bits;
        r_pend_value <= n_pend_value;
        r_pend_range <= n_pend_range;
        r_pend_bit   <= n_pend_bit;
        r_out_data   <= n_out_data;
    end

endmodule

/* rtl/bdeb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bdeb_step.sv */
// One equiprobable bit: split, compare, normalise, and flag a refill or a failed refill.
module bdeb_step (
    input  bdeb_pkg::t_coder i_coder,
    input  logic [12:0]      i_stream_end,
    output bdeb_pkg::t_step  o_step
);

    logic [8:0]  sum;
    logic [7:0]  split;
    logic [31:0] big;
    logic        ge;
    logic [7:0]  range1;
    logic [31:0] value1;
    logic        norm;
    logic [3:0]  count2;
    logic        last;

    always_comb begin
        sum    = {1'b0, i_coder.range} + 9'd1;
        split  = sum[8:1];
        big    = {split, {bdeb_pkg::SPLIT_SHIFT{1'b0}}};
        ge     = (i_coder.value >= big);
        range1 = ge ? (i_coder.range - split) : split;
        value1 = ge ? (i_coder.value - big) : i_coder.value;
        norm   = (range1 >= bdeb_pkg::RANGE_NORM);
        count2 = i_coder.count - 4'd1;
        last   = !norm && (count2 == 4'd0);

        o_step.fail    = last && (i_coder.position >= i_stream_end);
        o_step.refill  = last && !o_step.fail;
        o_step.value   = norm ? value1 : {value1[30:0], 1'b0};
        o_step.range   = norm ? range1 : {range1[6:0], 1'b0};
        o_step.count   = norm ? i_coder.count : count2;
        o_step.bit_out = ge && !o_step.fail;
    end

endmodule

/* rtl/bdeb_checker.sv */
// Port-level assertions for the boolean bit decoder, bound to the top level.
module bdeb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input bdeb_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bdeb_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid || i_out_ready)
        else $error("item taken while result slot blocked");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd == bdeb_pkg::CMD_START)
        |=> o_out_valid && !o_out_data.stream_error && (o_out_data.read_bits == 32'd0))
        else $error("start item did not clear error");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd != bdeb_pkg::CMD_READ)
        |=> o_out_valid && (o_out_data.read_bits == 32'd0))
        else $error("non-read item gave bits");

endmodule

bind bool_decoder_equiprobable_bits_top bdeb_checker u_bdeb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
